### src/htwd_pkg.sv
// Shared types and constants of the Huffman tree-walk decoder.
`default_nettype none

package htwd_pkg;

  localparam int IDX_W     = 9;
  localparam int SYM_W     = 8;
  localparam int LEN_W     = 24;
  localparam int CODE_W    = 8;
  localparam int BIT_CNT_W = $clog2(CODE_W + 1);

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // Child links and leaf flag of one tree node.
  typedef struct packed {
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic             leaf;
  } link_t;

  // Request from the sequencer to the output buffer.
  typedef struct packed {
    logic             push;
    logic             flush;
    logic [SYM_W-1:0] sym;
    logic             done;
  } emit_ctl_t;

endpackage

`default_nettype wire

### src/htwd_node_mem.sv
// Node table memory with one write port and one registered read port.
`default_nettype none

module htwd_node_mem
  import htwd_pkg::*;
#(
  parameter int NODE_COUNT  = 512,
  parameter int SYMBOL_BITS = 8
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [IDX_W-1:0]       waddr,
  input  wire link_t                  wlink,
  input  wire logic [SYM_W-1:0]       wsym,
  input  wire logic                   re,
  input  wire logic [IDX_W-1:0]       raddr,
  output link_t                       rlink,
  output logic      [SYMBOL_BITS-1:0] rsym
);

  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int DW = 2 * IDX_W + 1 + SYMBOL_BITS;

  logic [DW-1:0] mem [NODE_COUNT];
  logic [DW-1:0] rd_raw;
  logic          rd_zero;

  logic w_in_range;
  logic r_in_range;

  assign w_in_range = (32'(waddr) < NODE_COUNT);
  assign r_in_range = (32'(raddr) < NODE_COUNT);

  always_ff @(posedge clk) begin
    if (we && w_in_range) begin
      mem[AW'(waddr)] <= {wlink, SYMBOL_BITS'(wsym)};
    end
  end

  // An index beyond the table reads as an all-zero inner node.
  always_ff @(posedge clk) begin
    if (re) begin
      rd_zero <= !r_in_range;
      if (r_in_range) begin
        rd_raw <= mem[AW'(raddr)];
      end
    end
  end

  always_comb begin
    rlink = rd_zero ? '0 : link_t'(rd_raw[DW-1:SYMBOL_BITS]);
    rsym  = rd_zero ? '0 : rd_raw[SYMBOL_BITS-1:0];
  end

endmodule

`default_nettype wire

### src/htwd_out_buf.sv
// Output stage: one held symbol plus the output register, so that last can be set.
`default_nettype none

module htwd_out_buf
  import htwd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire emit_ctl_t        ctl,
  output logic                  out_free,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [SYM_W-1:0] symbol,
  output logic                  last,
  output logic                  done_res
);

  logic             pend_valid;
  logic [SYM_W-1:0] pend_sym;
  logic             pend_done;

  assign out_free = !out_valid || out_ready;

  // A held symbol goes out with last low when another follows, and with
  // last high when the code word is finished.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.push) begin
        if (pend_valid) begin
          out_valid <= 1'b1;
          symbol    <= pend_sym;
          done_res  <= pend_done;
          last      <= 1'b0;
        end
        pend_valid <= 1'b1;
        pend_sym   <= ctl.sym;
        pend_done  <= ctl.done;
      end else if (ctl.flush && pend_valid) begin
        out_valid  <= 1'b1;
        symbol     <= pend_sym;
        done_res   <= pend_done;
        last       <= 1'b1;
        pend_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### src/huffman_tree_walk_decoder.sv
// Top level of the Huffman tree-walk decoder: sequencer, registers and stages.
// A load word is written when accepted. A decode word takes one table lookup, one walk
// step per code bit walked (up to eight), one leaf test and one flush. A held-off output
// stalls the walk. Synchronous reset puts the walk at the root and clears the count and
// text_length; the node table is undefined until loaded.
`default_nettype none

module huffman_tree_walk_decoder
  import htwd_pkg::*;
#(
  parameter int NODE_COUNT  = 512,
  parameter int SYMBOL_BITS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             operation,
  input  wire logic [IDX_W-1:0] node_index,
  input  wire logic [IDX_W-1:0] left_child,
  input  wire logic [IDX_W-1:0] right_child,
  input  wire logic             node_is_leaf,
  input  wire logic [SYM_W-1:0] node_symbol,
  input  wire logic [CODE_W-1:0] code_byte,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [SYM_W-1:0] symbol,
  output logic                  last,
  output logic                  done_res,
  input  wire logic             cfg_we,
  input  wire logic [LEN_W-1:0] cfg_wdata
);

  // Sequencer states.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]           state;
  logic [1:0]           state_next;
  logic [LEN_W-1:0]     text_length;
  logic [LEN_W-1:0]     count;
  logic [IDX_W-1:0]     current_node;
  logic [CODE_W-1:0]    code_sh;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic                 have_child;
  link_t                root_link;

  // Node table interface.
  logic                   mem_re;
  logic [IDX_W-1:0]       mem_raddr;
  link_t                  rd_link;
  logic [SYMBOL_BITS-1:0] rd_sym;
  link_t                  load_link;

  // Walk step signals.
  logic             in_fire;
  logic             out_free;
  logic             advance;
  logic             leaf_hit;
  logic [LEN_W-1:0] count_next;
  logic             more;
  link_t            stand;
  logic [IDX_W-1:0] child;
  emit_ctl_t        emit;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign load_link.left  = left_child;
  assign load_link.right = right_child;
  assign load_link.leaf  = node_is_leaf;

  htwd_node_mem #(
    .NODE_COUNT  (NODE_COUNT),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_node_mem (
    .clk   (clk),
    .we    (in_fire && (operation == OP_LOAD)),
    .waddr (node_index),
    .wlink (load_link),
    .wsym  (node_symbol),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rlink (rd_link),
    .rsym  (rd_sym)
  );

  // One walk cycle. The read data holds the node reached by the previous bit,
  // or, on the first cycle of a word, the node the walk stands on. A newly
  // reached leaf emits its symbol and the walk stands on the root again,
  // whose links come from a shadow copy kept at load time. The next bit is
  // then taken from the standing node if bits remain and the length is not yet reached.
  always_comb begin
    advance    = out_free;
    leaf_hit   = have_child && rd_link.leaf;
    count_next = leaf_hit ? count + LEN_W'(1) : count;
    more       = (bit_cnt != BIT_CNT_W'(CODE_W)) && (count_next < text_length);
    stand      = leaf_hit ? root_link : rd_link;
    child      = code_sh[CODE_W-1] ? stand.right : stand.left;
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = child;
    unique case (state)
      S_IDLE: begin
        mem_re    = in_fire && (operation == OP_DECODE);
        mem_raddr = current_node;
      end
      S_WALK: begin
        mem_re = advance && more;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_comb begin
    emit.push  = (state == S_WALK) && advance && leaf_hit;
    emit.flush = (state == S_FLUSH) && out_free;
    emit.sym   = SYM_W'(rd_sym);
    emit.done  = (count_next == text_length);
  end

  htwd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .ctl       (emit),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .symbol    (symbol),
    .last      (last),
    .done_res  (done_res)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire && (operation == OP_DECODE)) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (advance && !more) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      text_length  <= '0;
      count        <= '0;
      current_node <= '0;
      have_child   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        text_length <= cfg_wdata;
      end
      if (in_fire && (operation == OP_DECODE)) begin
        have_child <= 1'b0;
      end else if ((state == S_WALK) && advance) begin
        count <= count_next;
        if (more) begin
          current_node <= child;
          have_child   <= 1'b1;
        end else if (leaf_hit) begin
          current_node <= '0;
        end
      end
    end
  end

  // Code bits and the bit counter; the root shadow follows loads of node 0.
  always_ff @(posedge clk) begin
    if (in_fire && (operation == OP_DECODE)) begin
      code_sh <= code_byte;
      bit_cnt <= '0;
    end else if ((state == S_WALK) && advance && more) begin
      code_sh <= {code_sh[CODE_W-2:0], 1'b0};
      bit_cnt <= bit_cnt + BIT_CNT_W'(1);
    end
    if (in_fire && (operation == OP_LOAD) && (node_index == '0)) begin
      root_link <= load_link;
    end
  end

endmodule

`default_nettype wire

### tb/sv/tb_huffman_tree_walk_decoder.sv
// Self-checking testbench for the Huffman tree-walk decoder: directed table, random trees and codes.
`timescale 1ns / 100ps

module tb_huffman_tree_walk_decoder;
  import htwd_pkg::*;

  localparam int NODES        = 512;
  // Longer than the slowest decode word takes, so this covers a word that emits nothing.
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 200;
  localparam int HOLD_AFTER   = 60;
  localparam int RANDOM_WORDS = 130;
  localparam int LIMIT_CYCLES = 200000;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // One input word with every field of the payload.
  typedef struct packed {
    logic              op;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  left;
    logic [IDX_W-1:0]  right;
    logic              leaf;
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] code;
  } tree_word_t;

  // One decoded symbol as it should leave the block.
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             last;
    logic             done;
  } decoded_sym_t;

  typedef enum logic {ROW_CONFIG, ROW_WORD} row_kind_t;
  typedef enum logic {CHK_MODEL, CHK_TYPED} row_check_t;

  // A row of the directed table. Typed rows expect n_syms copies of rep_sym,
  // with last on the final one and done on it too when ends_text is set.
  typedef struct packed {
    row_kind_t        kind;
    logic [LEN_W-1:0] len;
    tree_word_t       word;
    row_check_t       check;
    int               n_syms;
    logic [SYM_W-1:0] rep_sym;
    logic             ends_text;
  } stim_row_t;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              in_valid     = 1'b0;
  logic              in_ready;
  logic              operation    = OP_LOAD;
  logic [IDX_W-1:0]  node_index   = '0;
  logic [IDX_W-1:0]  left_child   = '0;
  logic [IDX_W-1:0]  right_child  = '0;
  logic              node_is_leaf = 1'b0;
  logic [SYM_W-1:0]  node_symbol  = '0;
  logic [CODE_W-1:0] code_byte    = '0;
  logic              out_valid;
  logic              out_ready    = 1'b0;
  logic [SYM_W-1:0]  symbol;
  logic              last;
  logic              done_res;
  logic              cfg_we       = 1'b0;
  logic [LEN_W-1:0]  cfg_wdata    = '0;

  always #5 clk = ~clk;

  huffman_tree_walk_decoder u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .node_index   (node_index),
    .left_child   (left_child),
    .right_child  (right_child),
    .node_is_leaf (node_is_leaf),
    .node_symbol  (node_symbol),
    .code_byte    (code_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .symbol       (symbol),
    .last         (last),
    .done_res     (done_res),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  // Shadow copy of the decoder state. Entries of the node table are only read
  // once loaded: every load points its children at nodes that are loaded, or
  // that belong to the same tree, and code words only follow complete trees.
  link_t            node_links  [NODES];
  logic [SYM_W-1:0] node_syms   [NODES];
  bit               node_loaded [NODES];
  logic [IDX_W-1:0] walk_node     = '0;
  logic [LEN_W-1:0] emitted_count = '0;
  logic [LEN_W-1:0] text_len      = '0;
  decoded_sym_t     pending_syms [$];

  int error_count     = 0;
  int checked_syms    = 0;
  int load_words      = 0;
  int code_words      = 0;
  int length_settings = 0;
  int cycle_count     = 0;
  // While calm is set, neither side idles at random, but the long hold-off still applies.
  bit calm            = 1'b0;

  // Applies one accepted word to the shadow state. A load writes the table.
  // A code word walks its bits MSB first until the text length is reached,
  // emitting a symbol and returning to the root at every leaf.
  function automatic void walk_word(input tree_word_t w, input bit queue_syms);
    decoded_sym_t batch [CODE_W];
    int           n;
    int           pos;
    n = 0;
    if (w.op == OP_LOAD) begin
      node_links[w.idx]  = {w.left, w.right, w.leaf};
      node_syms[w.idx]   = w.sym;
      node_loaded[w.idx] = 1'b1;
    end else begin
      for (pos = CODE_W - 1; pos >= 0 && emitted_count < text_len; pos--) begin
        walk_node = w.code[pos] ? node_links[walk_node].right : node_links[walk_node].left;
        if (node_links[walk_node].leaf) begin
          emitted_count = emitted_count + 1'b1;
          batch[n].sym  = node_syms[walk_node];
          batch[n].done = (emitted_count == text_len);
          n++;
          walk_node = '0;
        end
      end
      if (queue_syms) begin
        for (int i = 0; i < n; i++) begin
          batch[i].last = (i == n - 1);
          pending_syms.push_back(batch[i]);
        end
      end
    end
  endfunction

  // Every field random, so the fields a word does not use toggle as well.
  function automatic tree_word_t random_word();
    tree_word_t w;
    w.op    = 1'($urandom_range(1));
    w.idx   = IDX_W'($urandom_range(NODES - 1));
    w.left  = IDX_W'($urandom_range(NODES - 1));
    w.right = IDX_W'($urandom_range(NODES - 1));
    w.leaf  = 1'($urandom_range(1));
    w.sym   = SYM_W'($urandom_range(255));
    w.code  = CODE_W'($urandom_range(255));
    return w;
  endfunction

  function automatic logic [IDX_W-1:0] any_loaded_node();
    logic [IDX_W-1:0] idx;
    idx = IDX_W'($urandom_range(NODES - 1));
    while (!node_loaded[idx]) idx = IDX_W'($urandom_range(NODES - 1));
    return idx;
  endfunction

  function automatic stim_row_t config_row(input logic [LEN_W-1:0] value);
    stim_row_t r;
    r        = '0;
    r.kind   = ROW_CONFIG;
    r.len    = value;
    return r;
  endfunction

  function automatic stim_row_t load_row(input int idx, input int left, input int right,
                                         input bit leaf, input logic [SYM_W-1:0] sym);
    stim_row_t r;
    r            = '0;
    r.kind       = ROW_WORD;
    r.check      = CHK_MODEL;
    r.word       = random_word();
    r.word.op    = OP_LOAD;
    r.word.idx   = IDX_W'(idx);
    r.word.left  = IDX_W'(left);
    r.word.right = IDX_W'(right);
    r.word.leaf  = leaf;
    r.word.sym   = sym;
    return r;
  endfunction

  function automatic stim_row_t code_row(input logic [CODE_W-1:0] code);
    stim_row_t r;
    r           = '0;
    r.kind      = ROW_WORD;
    r.check     = CHK_MODEL;
    r.word      = random_word();
    r.word.op   = OP_DECODE;
    r.word.code = code;
    return r;
  endfunction

  function automatic stim_row_t typed_code_row(input logic [CODE_W-1:0] code, input int n,
                                               input logic [SYM_W-1:0] sym, input bit ends);
    stim_row_t r;
    r           = code_row(code);
    r.check     = CHK_TYPED;
    r.n_syms    = n;
    r.rep_sym   = sym;
    r.ends_text = ends;
    return r;
  endfunction

  // Offers one word and holds it until accepted. The ready is sampled at the
  // falling edge, where every signal is settled, and the word counts as
  // taken at the rising edge that follows. Returns on that rising edge.
  task automatic send_word(input tree_word_t w, input bit use_model);
    bit taken;
    if (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= w.op;
    node_index   <= w.idx;
    left_child   <= w.left;
    right_child  <= w.right;
    node_is_leaf <= w.leaf;
    node_symbol  <= w.sym;
    code_byte    <= w.code;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end
    walk_word(w, use_model);
    if (w.op == OP_LOAD) load_words++;
    else code_words++;
  endtask

  // Waits until every expected symbol has been seen and the block is idle.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_syms.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_text_length(input logic [LEN_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    text_len = value;
    length_settings++;
  endtask

  // Builds a random full binary tree with 2 to 12 leaves, places its nodes at
  // distinct random indexes with the root at 0, and loads them in random
  // order. Leaf children are never walked from a leaf, but they still point
  // inside the tree so that every link in the table stays loaded.
  task automatic load_random_tree();
    int               n_nodes;
    int               leaves;
    int               pick;
    int               tmp;
    bit               is_leaf  [32];
    int               left_of  [32];
    int               right_of [32];
    logic [IDX_W-1:0] idx_of   [32];
    int               order    [32];
    bit               taken    [NODES];
    tree_word_t       w;
    n_nodes    = 1;
    is_leaf[0] = 1'b1;
    leaves     = $urandom_range(2, 12);
    for (int k = 1; k < leaves; k++) begin
      pick = $urandom_range(n_nodes - 1);
      while (!is_leaf[pick]) pick = $urandom_range(n_nodes - 1);
      is_leaf[pick]      = 1'b0;
      left_of[pick]      = n_nodes;
      right_of[pick]     = n_nodes + 1;
      is_leaf[n_nodes]   = 1'b1;
      is_leaf[n_nodes+1] = 1'b1;
      n_nodes += 2;
    end
    idx_of[0] = '0;
    taken[0]  = 1'b1;
    order[0]  = 0;
    for (int j = 1; j < n_nodes; j++) begin
      tmp = $urandom_range(1, NODES - 1);
      while (taken[tmp]) tmp = $urandom_range(1, NODES - 1);
      taken[tmp] = 1'b1;
      idx_of[j]  = IDX_W'(tmp);
      order[j]   = j;
    end
    for (int j = n_nodes - 1; j > 0; j--) begin
      pick         = $urandom_range(j);
      tmp          = order[j];
      order[j]     = order[pick];
      order[pick]  = tmp;
    end
    for (int j = 0; j < n_nodes; j++) begin
      w      = random_word();
      w.op   = OP_LOAD;
      w.idx  = idx_of[order[j]];
      w.leaf = is_leaf[order[j]];
      if (w.leaf) begin
        w.left  = idx_of[$urandom_range(n_nodes - 1)];
        w.right = idx_of[$urandom_range(n_nodes - 1)];
      end else begin
        w.left  = idx_of[left_of[order[j]]];
        w.right = idx_of[right_of[order[j]]];
      end
      send_word(w, 1'b1);
    end
  endtask

  // Result side: random back-pressure, one long hold-off once the run is well
  // under way, and a field-by-field check of every accepted symbol.
  initial begin : result_sink
    decoded_sym_t want;
    int           hold_left;
    bit           held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!held && checked_syms >= HOLD_AFTER) begin
        // The sender keeps offering words meanwhile, so the block fills up
        // and has to stall its input.
        held      = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 9);
      end
      @(negedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_syms.size() == 0) begin
          $error("symbol %0h arrived while nothing was expected", symbol);
          error_count++;
        end else begin
          want = pending_syms.pop_front();
          if (symbol !== want.sym) begin
            $error("symbol: expected %0h, got %0h", want.sym, symbol);
            error_count++;
          end
          if (last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last);
            error_count++;
          end
          if (done_res !== want.done) begin
            $error("done_res: expected %0b, got %0b", want.done, done_res);
            error_count++;
          end
          checked_syms++;
        end
      end
    end
  end

  // Watchdog: far above the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("run timed out after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t    rows [$];
    decoded_sym_t exp_sym;
    tree_word_t   w;
    logic [LEN_W-1:0] new_len;
    int           phase;
    int           first_random;

    // Small tree: root 0 splits into leaf 1 (symbol 00) and inner node 2,
    // which splits into leaf 3 (symbol FF) and leaf 4 (symbol A5).
    rows.push_back(load_row(0, 1, 2, 1'b0, 8'h00));
    rows.push_back(load_row(1, 0, 0, 1'b1, 8'h00));
    rows.push_back(load_row(2, 3, 4, 1'b0, 8'hFF));
    rows.push_back(load_row(3, 0, 0, 1'b1, 8'hFF));
    rows.push_back(load_row(4, 0, 0, 1'b1, 8'hA5));
    // Text length is 0 after reset, so nothing may come out.
    rows.push_back(typed_code_row(8'hFF, 0, 8'h00, 1'b0));
    // Eight zero bits find eight leaves, but the length cuts it at five.
    rows.push_back(config_row(5));
    rows.push_back(typed_code_row(8'h00, 5, 8'h00, 1'b1));
    rows.push_back(typed_code_row(8'hFF, 0, 8'h00, 1'b0));
    rows.push_back(config_row(LEN_MAX));
    rows.push_back(typed_code_row(8'hFF, 4, 8'hA5, 1'b0));
    rows.push_back(code_row(8'hA0));
    // This byte ends on inner node 2, and the next one goes on from there.
    rows.push_back(code_row(8'h01));
    rows.push_back(code_row(8'h7F));
    // Highest table entry as a leaf, then reloading node 2 to reach it.
    rows.push_back(load_row(NODES - 1, NODES - 1, NODES - 1, 1'b1, 8'h5A));
    rows.push_back(load_row(2, 3, NODES - 1, 1'b0, 8'h00));
    rows.push_back(code_row(8'hFF));
    rows.push_back(code_row(8'h55));
    // Length lowered below the count, then zero: the walk must not move.
    rows.push_back(config_row(3));
    rows.push_back(typed_code_row(8'h00, 0, 8'h00, 1'b0));
    rows.push_back(config_row(0));
    rows.push_back(typed_code_row(8'hFF, 0, 8'h00, 1'b0));
    // The count is 34 here; two more symbols finish the text mid-byte.
    rows.push_back(config_row(36));
    rows.push_back(code_row(8'h00));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CONFIG) begin
        settle();
        write_text_length(rows[i].len);
      end else begin
        send_word(rows[i].word, rows[i].check == CHK_MODEL);
        if (rows[i].check == CHK_TYPED) begin
          for (int k = 0; k < rows[i].n_syms; k++) begin
            exp_sym.sym  = rows[i].rep_sym;
            exp_sym.last = (k == rows[i].n_syms - 1);
            exp_sym.done = rows[i].ends_text && (k == rows[i].n_syms - 1);
            pending_syms.push_back(exp_sym);
          end
        end
      end
    end

    // Random phases: a new text length each time, often a fresh tree, then
    // a run of code bytes with a few stray loads mixed in. Phases 1 and 2
    // run without random idling on either side.
    phase        = 0;
    first_random = load_words + code_words;
    while (load_words + code_words - first_random < RANDOM_WORDS) begin
      settle();
      calm = (phase == 1 || phase == 2);
      case ($urandom_range(9))
        0:       new_len = '0;
        1:       new_len = LEN_MAX;
        2:       new_len = emitted_count;
        default: new_len = LEN_W'(emitted_count + $urandom_range(1, 30));
      endcase
      write_text_length(new_len);
      if (phase == 0 || $urandom_range(2) == 0) load_random_tree();
      repeat ($urandom_range(8, 20)) begin
        w = random_word();
        if ($urandom_range(99) < 8) begin
          // Stray load: links only to loaded entries, and the root stays inner.
          w.op    = OP_LOAD;
          w.left  = any_loaded_node();
          w.right = any_loaded_node();
          if (w.idx == '0) w.leaf = 1'b0;
        end else begin
          w.op = OP_DECODE;
        end
        send_word(w, 1'b1);
      end
      phase++;
    end

    calm = 1'b0;
    settle();
    $display("Covered %0d code bytes and %0d node loads over %0d text length settings;",
             code_words, load_words, length_settings);
    $display("%0d decoded symbols were checked with their last and done flags.", checked_syms);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
